[design/least_connections_balancer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the least-connections balancer
// Shorthand for clocked assertions that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef LEAST_CONNECTIONS_BALANCER_ASSERT_SVH
`define LEAST_CONNECTIONS_BALANCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lcb_pkg.sv]
// ----------------------------------------------------------------------------
// Least-connections balancer package
// Widths, codes, payload types and controller interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcb_pkg;

    localparam int MAX_CLIENTS = 32;
    localparam int MAX_SERVERS = 16;

    localparam int CLIENT_W  = $clog2(MAX_CLIENTS);
    localparam int SRV_W     = $clog2(MAX_SERVERS);
    localparam int NSRV_W    = 5;
    localparam int TIMEOUT_W = 8;
    localparam int LOAD_W    = 6;
    localparam int TIME_W    = 16;
    localparam int EV_W      = 3;
    localparam int MODE_W    = 2;
    localparam int IDX_W     = 1;
    localparam int DATA_W    = 8;

    localparam logic [NSRV_W-1:0]    NUM_SRV_RST = NSRV_W'(1);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(30);

    localparam logic [IDX_W-1:0] REG_NUM_SERVERS  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_IDLE_TIMEOUT = IDX_W'(1);

    localparam logic [MODE_W-1:0] MODE_OPEN     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLOSE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ACTIVITY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd3;

    localparam logic [EV_W-1:0] EV_OPENED       = 3'd0;
    localparam logic [EV_W-1:0] EV_REJECTED     = 3'd1;
    localparam logic [EV_W-1:0] EV_CLOSED       = 3'd2;
    localparam logic [EV_W-1:0] EV_CLOSE_IGN    = 3'd3;
    localparam logic [EV_W-1:0] EV_TIMED_OUT    = 3'd4;
    localparam logic [EV_W-1:0] EV_TICK_DONE    = 3'd5;
    localparam logic [EV_W-1:0] EV_ACTIVITY_OK  = 3'd6;
    localparam logic [EV_W-1:0] EV_ACTIVITY_IGN = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [CLIENT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic [EV_W-1:0]     event_res;
        logic [CLIENT_W-1:0] slot_index;
        logic [SRV_W-1:0]    server;
        logic [LOAD_W-1:0]   server_load;
        logic                last;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_MOD,
        ST_SCAN,
        ST_COMMIT,
        ST_REJECT,
        ST_CLOSE_RD,
        ST_CLOSE,
        ST_ACT_RD,
        ST_ACT,
        ST_TICK_INC,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_TICK_END
    } state_t;

    typedef struct packed {
        logic capture;
        logic find_inc;
        logic mod_step;
        logic best_init;
        logic scan_step;
        logic commit;
        logic reject;
        logic close_do;
        logic act_do;
        logic tick_inc;
        logic tick_rd;
        logic tick_chk;
        logic tick_end;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic cnt_last;
        logic ptr_ge_n;
        logic scan_done;
    } status_t;

endpackage

`default_nettype wire

[design/lcb_ctrl.sv]
// ----------------------------------------------------------------------------
// Least-connections balancer controller
// Sequences open, close, activity and tick requests over the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcb_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [lcb_pkg::MODE_W-1:0] mode,
    input  wire lcb_pkg::status_t          status,
    output lcb_pkg::cmd_t                  cmd,
    output logic                           busy
);
    import lcb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (mode)
                        MODE_OPEN:     state_next = ST_FIND;
                        MODE_CLOSE:    state_next = ST_CLOSE_RD;
                        MODE_ACTIVITY: state_next = ST_ACT_RD;
                        MODE_TICK:     state_next = ST_TICK_INC;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FIND:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_MOD;
                end
                else if (status.cnt_last)
                begin
                    state_next = ST_REJECT;
                end
            end
            ST_MOD:
            begin
                if (!status.ptr_ge_n)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:   state_next = ST_IDLE;
            ST_REJECT:   state_next = ST_IDLE;
            ST_CLOSE_RD: state_next = ST_CLOSE;
            ST_CLOSE:    state_next = ST_IDLE;
            ST_ACT_RD:   state_next = ST_ACT;
            ST_ACT:      state_next = ST_IDLE;
            ST_TICK_INC: state_next = ST_TICK_RD;
            ST_TICK_RD:  state_next = ST_TICK_CHK;
            ST_TICK_CHK: state_next = status.cnt_last ? ST_TICK_END : ST_TICK_RD;
            ST_TICK_END: state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:     cmd.capture   = start;
            ST_FIND:     cmd.find_inc  = !status.slot_free && !status.cnt_last;
            ST_MOD:
            begin
                cmd.mod_step  = status.ptr_ge_n;
                cmd.best_init = !status.ptr_ge_n;
            end
            ST_SCAN:     cmd.scan_step = !status.scan_done;
            ST_COMMIT:   cmd.commit    = 1'b1;
            ST_REJECT:   cmd.reject    = 1'b1;
            ST_CLOSE_RD: cmd.close_do  = 1'b0;
            ST_CLOSE:    cmd.close_do  = 1'b1;
            ST_ACT_RD:   cmd.act_do    = 1'b0;
            ST_ACT:      cmd.act_do    = 1'b1;
            ST_TICK_INC: cmd.tick_inc  = 1'b1;
            ST_TICK_RD:  cmd.tick_rd   = 1'b1;
            ST_TICK_CHK: cmd.tick_chk  = 1'b1;
            ST_TICK_END: cmd.tick_end  = 1'b1;
            default:     cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

[design/lcb_datapath.sv]
// ----------------------------------------------------------------------------
// Least-connections balancer datapath
// Holds server loads, slot tables, time, configuration and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcb_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lcb_pkg::req_t               req,
    input  wire logic                        wr_en,
    input  wire logic [lcb_pkg::IDX_W-1:0]   wr_index,
    input  wire logic [lcb_pkg::DATA_W-1:0]  wr_data,
    input  wire lcb_pkg::cmd_t               cmd,
    output lcb_pkg::status_t                 status,
    output lcb_pkg::rsp_t                    result,
    output logic                             result_valid
);
    import lcb_pkg::*;

    localparam logic [LOAD_W-1:0]   LOAD_MAX   = '1;
    localparam logic [CLIENT_W-1:0] CLIENT_END = CLIENT_W'(MAX_CLIENTS - 1);

    logic [NSRV_W-1:0]    num_srv_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    logic [LOAD_W-1:0]      load_reg [MAX_SERVERS];
    logic [MAX_CLIENTS-1:0] busy_reg;
    logic [MAX_CLIENTS-1:0] busy_next;
    logic [TIME_W-1:0]      time_reg;
    logic [SRV_W-1:0]       ptr_reg;

    logic [CLIENT_W-1:0] slot_req_reg;
    logic [CLIENT_W-1:0] cnt_reg;
    logic [SRV_W-1:0]    ptr_work_reg;
    logic [SRV_W-1:0]    best_reg;
    logic [SRV_W-1:0]    cur_reg;
    logic [LOAD_W-1:0]   best_load_reg;
    logic [SRV_W-1:0]    steps_reg;

    logic [SRV_W-1:0]  srv_mem  [MAX_CLIENTS];
    logic [TIME_W-1:0] seen_mem [MAX_CLIENTS];
    logic [SRV_W-1:0]  srv_q;
    logic [TIME_W-1:0] seen_q;

    rsp_t pend_reg;
    rsp_t pend_next;
    logic pend_valid_reg;
    logic pend_valid_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;

    logic [NSRV_W-1:0]   n_use;
    logic [NSRV_W-1:0]   cur_inc;
    logic [SRV_W-1:0]    cur_nxt;
    logic [NSRV_W-1:0]   ptr_inc;
    logic [SRV_W-1:0]    ptr_adv;
    logic [SRV_W-1:0]    lrd_addr;
    logic [LOAD_W-1:0]   load_rd;
    logic [LOAD_W-1:0]   load_inc;
    logic [LOAD_W-1:0]   load_dec;
    logic [CLIENT_W-1:0] rd_addr;
    logic [TIME_W-1:0]   idle;
    logic                timed_out;
    logic                req_busy;
    logic                release_tick;
    logic                release_close;

    always_comb
    begin
        if (num_srv_reg == '0)
        begin
            n_use = NSRV_W'(1);
        end
        else if (num_srv_reg > NSRV_W'(MAX_SERVERS))
        begin
            n_use = NSRV_W'(MAX_SERVERS);
        end
        else
        begin
            n_use = num_srv_reg;
        end
    end

    assign cur_inc = {1'b0, cur_reg} + NSRV_W'(1);
    assign cur_nxt = (cur_inc == n_use) ? '0 : cur_inc[SRV_W-1:0];
    assign ptr_inc = {1'b0, ptr_work_reg} + NSRV_W'(1);
    assign ptr_adv = (ptr_inc == n_use) ? '0 : ptr_inc[SRV_W-1:0];

    always_comb
    begin
        if (cmd.scan_step)
        begin
            lrd_addr = cur_nxt;
        end
        else if (cmd.best_init)
        begin
            lrd_addr = ptr_work_reg;
        end
        else if (cmd.commit)
        begin
            lrd_addr = best_reg;
        end
        else
        begin
            lrd_addr = srv_q;
        end
    end

    assign load_rd  = load_reg[lrd_addr];
    assign load_inc = (load_rd == LOAD_MAX) ? LOAD_MAX : load_rd + LOAD_W'(1);
    assign load_dec = (load_rd == '0) ? '0 : load_rd - LOAD_W'(1);

    assign rd_addr       = cmd.tick_rd ? cnt_reg : slot_req_reg;
    assign idle          = time_reg - seen_q;
    assign timed_out     = busy_reg[cnt_reg] && (idle > TIME_W'(timeout_reg));
    assign req_busy      = busy_reg[slot_req_reg];
    assign release_tick  = cmd.tick_chk && timed_out;
    assign release_close = cmd.close_do && req_busy;

    assign status.slot_free = !busy_reg[cnt_reg];
    assign status.cnt_last  = (cnt_reg == CLIENT_END);
    assign status.ptr_ge_n  = ({1'b0, ptr_work_reg} >= n_use);
    assign status.scan_done = (best_load_reg == '0) || (steps_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_srv_reg <= NUM_SRV_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_NUM_SERVERS:  num_srv_reg <= wr_data[NSRV_W-1:0];
                REG_IDLE_TIMEOUT: timeout_reg <= wr_data[TIMEOUT_W-1:0];
                default:          num_srv_reg <= num_srv_reg;
            endcase
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (cmd.commit)
        begin
            busy_next[cnt_reg] = 1'b1;
        end
        if (release_close)
        begin
            busy_next[slot_req_reg] = 1'b0;
        end
        if (release_tick)
        begin
            busy_next[cnt_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            time_reg <= '0;
            ptr_reg  <= '0;
            for (int i = 0; i < MAX_SERVERS; i++)
            begin
                load_reg[i] <= '0;
            end
        end
        else
        begin
            busy_reg <= busy_next;
            if (cmd.tick_inc)
            begin
                time_reg <= time_reg + TIME_W'(1);
            end
            if (cmd.commit)
            begin
                ptr_reg            <= ptr_adv;
                load_reg[best_reg] <= load_inc;
            end
            if (release_close || release_tick)
            begin
                load_reg[srv_q] <= load_dec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_req_reg <= req.slot;
            ptr_work_reg <= ptr_reg;
        end
        else if (cmd.mod_step)
        begin
            ptr_work_reg <= ptr_work_reg - n_use[SRV_W-1:0];
        end
        if (cmd.capture || cmd.tick_inc)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.find_inc || (cmd.tick_chk && !status.cnt_last))
        begin
            cnt_reg <= cnt_reg + CLIENT_W'(1);
        end
        if (cmd.best_init)
        begin
            best_reg      <= ptr_work_reg;
            cur_reg       <= ptr_work_reg;
            best_load_reg <= load_rd;
            steps_reg     <= SRV_W'(n_use - NSRV_W'(1));
        end
        else if (cmd.scan_step)
        begin
            cur_reg   <= cur_nxt;
            steps_reg <= steps_reg - SRV_W'(1);
            if (best_load_reg > load_rd)
            begin
                best_reg      <= cur_nxt;
                best_load_reg <= load_rd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            srv_mem[cnt_reg]  <= best_reg;
            seen_mem[cnt_reg] <= time_reg;
        end
        else if (cmd.act_do && req_busy)
        begin
            seen_mem[slot_req_reg] <= time_reg;
        end
        srv_q  <= srv_mem[rd_addr];
        seen_q <= seen_mem[rd_addr];
    end

    always_comb
    begin
        rsp_next        = '0;
        rsp_valid_next  = 1'b0;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{EV_OPENED, cnt_reg, best_reg, load_inc, 1'b1};
        end
        else if (cmd.reject)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{EV_REJECTED, '0, '0, '0, 1'b1};
        end
        else if (cmd.close_do)
        begin
            rsp_valid_next = 1'b1;
            if (req_busy)
            begin
                rsp_next = '{EV_CLOSED, slot_req_reg, srv_q, load_dec, 1'b1};
            end
            else
            begin
                rsp_next = '{EV_CLOSE_IGN, slot_req_reg, '0, '0, 1'b1};
            end
        end
        else if (cmd.act_do)
        begin
            rsp_valid_next = 1'b1;
            if (req_busy)
            begin
                rsp_next = '{EV_ACTIVITY_OK, slot_req_reg, srv_q, load_rd, 1'b1};
            end
            else
            begin
                rsp_next = '{EV_ACTIVITY_IGN, slot_req_reg, '0, '0, 1'b1};
            end
        end
        else if (cmd.tick_inc)
        begin
            pend_valid_next = 1'b0;
        end
        else if (release_tick)
        begin
            rsp_valid_next  = pend_valid_reg;
            rsp_next        = pend_reg;
            pend_next       = '{EV_TIMED_OUT, cnt_reg, srv_q, load_dec, 1'b0};
            pend_valid_next = 1'b1;
        end
        else if (cmd.tick_end)
        begin
            rsp_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                rsp_next      = pend_reg;
                rsp_next.last = 1'b1;
            end
            else
            begin
                rsp_next = '{EV_TICK_DONE, '0, '0, '0, 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg  <= rsp_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        pend_reg <= pend_next;
    end

    assign result       = rsp_reg;
    assign result_valid = rsp_valid_reg;

endmodule

`default_nettype wire

[design/least_connections_balancer.sv]
// Open: search the slot table for a free slot, bring the pointer below the server count,
// scan the servers for the least load, then commit; the result follows in the next cycle.
// Close and activity read the slot table, then act on the slot. A tick advances time,
// then reads and checks each slot in turn through the registered slot-table read port.
// One request is in flight at a time; busy falls in the cycle of its final result.
// Results cannot be stalled. Reset clears all loads, busy bits, time and the pointer.
// ----------------------------------------------------------------------------
// Least-connections balancer top level
// Connection tracker that assigns, releases and times out client slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "least_connections_balancer_assert.svh"

module least_connections_balancer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire lcb_pkg::req_t               req,
    input  wire logic                        wr_en,
    input  wire logic [lcb_pkg::IDX_W-1:0]   wr_index,
    input  wire logic [lcb_pkg::DATA_W-1:0]  wr_data,
    output lcb_pkg::rsp_t                    result,
    output logic                             result_valid
);
    import lcb_pkg::*;

    cmd_t    cmd;
    status_t status;

    lcb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (req.mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lcb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

    `LCB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not start work")
    `LCB_ASSERT_SAME(a_more_follow, result_valid && !result.last, busy, "non-final result while idle")
    `LCB_ASSERT_SAME(a_idle_last, result_valid && !busy, result.last, "idle result not marked last")

endmodule

`default_nettype wire
